// File: rtl/core/trle_pkg.sv
// ----------------------------------------------------------------------------
// trle_pkg
// Shared types and constants for the run-length pixel decoder.
// ----------------------------------------------------------------------------
package trle_pkg;

   localparam int unsigned ByteWidth      = 8;
   localparam int unsigned CsrIndexWidth  = 2;
   localparam int unsigned CsrDataWidth   = 16;
   localparam int unsigned DimWidth       = 16;
   localparam int unsigned PixelCntWidth  = 2 * DimWidth;
   localparam int unsigned RspDataWidth   = 40;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_RLE_MODE        = 2'd0,
      CSR_BYTES_PER_PIXEL = 2'd1,
      CSR_IMAGE_WIDTH     = 2'd2,
      CSR_IMAGE_HEIGHT    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ByteWidth-1:0] repeat_count;
      logic [ByteWidth-1:0] alpha;
      logic [ByteWidth-1:0] blue;
      logic [ByteWidth-1:0] green;
      logic [ByteWidth-1:0] red;
      logic                 last_pixel;
   } pixel_type;

endpackage

// File: rtl/core/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Decodes raw or run-length packed pixel bytes into RGBA pixels with counts.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one pixel-data byte per beat (req_tdata[7:0]).
//   rsp_* : one decoded pixel per beat; tdata holds red, green, blue, alpha,
//           repeat_count from the low bits up; tlast marks the pixel that
//           completes the image. Packet bytes and partial pixels give no beat.
//   csr_* : register writes (index, data), always ready; write only while
//           no beat is in flight. A new width or height is used from the
//           next accepted byte on.
// Throughput: one byte per cycle while the result buffer is not full, set by the
//   single-pass decode between the input register and the result register.
// Path: a pixel's final byte is held in the input register and decoded into the result buffer, which drives rsp_.
// Reset: registers return to uncompressed, 4 bytes per pixel, 1x1 image;
//   the stream waits for the first byte of a new image.
// Stall: a two-entry result buffer absorbs a stalled receiver; req_tready
//   drops only while both entries are full and a byte waits to be decoded.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder
   import trle_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [ByteWidth-1:0]      req_tdata,    // [7:0] data_byte
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RspDataWidth-1:0]   rsp_tdata,    // red, green, blue, alpha, repeat_count
   output logic                      rsp_tlast,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CsrIndexWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0]   csr_data
);

   // configuration
   logic                     rle_mode_ff;
   logic [2:0]               bpp_ff;
   logic [DimWidth-1:0]      width_ff, width_in;
   logic [DimWidth-1:0]      height_ff, height_in;
   logic [PixelCntWidth-1:0] total_ff;

   // input register
   logic                     in_valid_ff;
   logic [ByteWidth-1:0]     in_byte_ff;

   // stream state
   logic                     expect_ff, expect_in;
   logic                     is_run_ff, is_run_in;
   logic [6:0]               raw_left_ff, raw_left_in;
   logic [1:0]               pos_ff, pos_in;
   logic [23:0]              gathered_ff, gathered_in;
   logic [PixelCntWidth-1:0] done_ff, done_in;
   logic [ByteWidth-1:0]     run_len_ff, run_len_in;

   // result buffer
   logic                     main_valid_ff, skid_valid_ff;
   pixel_type                main_ff, skid_ff;

   logic                     fire, push, pop;
   logic                     packet_phase, gather, complete;
   logic [2:0]               bpp_eff;
   logic [2:0]               pos_next;
   logic [ByteWidth-1:0]     b0, b1, b2;
   logic [ByteWidth-1:0]     count_raw, count;
   logic [PixelCntWidth-1:0] remaining;
   logic                     last;
   pixel_type                result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rle_mode_ff <= 1'b0;
         bpp_ff      <= 3'd4;
         width_ff    <= DimWidth'(1);
         height_ff   <= DimWidth'(1);
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_RLE_MODE:        rle_mode_ff <= csr_data[0];
            CSR_BYTES_PER_PIXEL: bpp_ff      <= csr_data[2:0];
            CSR_IMAGE_WIDTH:     width_ff    <= csr_data;
            CSR_IMAGE_HEIGHT:    height_ff   <= csr_data;
            default:             ;
         endcase
      end
   end

   assign width_in  = (csr_valid && (csr_index_type'(csr_index) == CSR_IMAGE_WIDTH))
                      ? csr_data : width_ff;
   assign height_in = (csr_valid && (csr_index_type'(csr_index) == CSR_IMAGE_HEIGHT))
                      ? csr_data : height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= PixelCntWidth'(1);
      end else begin
         total_ff <= PixelCntWidth'(width_in) * PixelCntWidth'(height_in);
      end
   end

   // decode
   always_comb begin
      if (bpp_ff < 3'd3)      bpp_eff = 3'd2;
      else if (bpp_ff > 3'd4) bpp_eff = 3'd4;
      else                    bpp_eff = bpp_ff;
   end

   assign pos_next     = {1'b0, pos_ff} + 3'd1;
   assign packet_phase = rle_mode_ff && expect_ff;
   assign gather       = !packet_phase && (pos_next < bpp_eff);
   assign complete     = !packet_phase && !gather;

   assign b0 = gathered_ff[7:0];
   assign b1 = gathered_ff[15:8];
   assign b2 = gathered_ff[23:16];

   assign count_raw = (rle_mode_ff && is_run_ff) ? run_len_ff : ByteWidth'(1);
   assign remaining = (total_ff > done_ff) ? (total_ff - done_ff) : PixelCntWidth'(1);
   assign count     = ({{(PixelCntWidth-ByteWidth){1'b0}}, count_raw} > remaining)
                      ? remaining[ByteWidth-1:0] : count_raw;
   assign last      = ({{(PixelCntWidth-ByteWidth){1'b0}}, count} == remaining);

   always_comb begin
      case (bpp_eff)
         3'd4: begin
            result.red   = b2;
            result.green = b1;
            result.blue  = b0;
            result.alpha = in_byte_ff;
         end
         3'd3: begin
            result.red   = in_byte_ff;
            result.green = b1;
            result.blue  = b0;
            result.alpha = 8'hff;
         end
         default: begin   // 1-5-5-5
            result.red   = {in_byte_ff[6:2], 3'b000};
            result.green = {in_byte_ff[1:0], b0[7:5], 3'b000};
            result.blue  = {b0[4:0], 3'b000};
            result.alpha = {in_byte_ff[7], 7'b0};
         end
      endcase
      result.repeat_count = count;
      result.last_pixel   = last;
   end

   // handshake
   assign fire       = in_valid_ff && !skid_valid_ff;
   assign push       = fire && complete;
   assign pop        = main_valid_ff && rsp_tready;
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   // stream state update
   always_comb begin
      expect_in   = expect_ff;
      is_run_in   = is_run_ff;
      raw_left_in = raw_left_ff;
      pos_in      = pos_ff;
      gathered_in = gathered_ff;
      done_in     = done_ff;
      run_len_in  = run_len_ff;
      if (packet_phase) begin
         is_run_in   = in_byte_ff[7];
         run_len_in  = in_byte_ff[7] ? ({1'b0, in_byte_ff[6:0]} + 8'd1) : 8'd1;
         raw_left_in = in_byte_ff[7] ? 7'd0 : in_byte_ff[6:0];
         expect_in   = 1'b0;
         pos_in      = 2'd0;
         gathered_in = 24'd0;
      end else if (gather) begin
         case (pos_ff)
            2'd0:    gathered_in[7:0]   = in_byte_ff;
            2'd1:    gathered_in[15:8]  = in_byte_ff;
            default: gathered_in[23:16] = in_byte_ff;
         endcase
         pos_in = pos_next[1:0];
      end else begin
         pos_in      = 2'd0;
         gathered_in = 24'd0;
         if (last) begin
            expect_in   = 1'b1;
            is_run_in   = 1'b0;
            raw_left_in = 7'd0;
            done_in     = '0;
            run_len_in  = 8'd1;
         end else begin
            done_in = done_ff + {{(PixelCntWidth-ByteWidth){1'b0}}, count};
            if (rle_mode_ff) begin
               if (is_run_ff || raw_left_ff == 7'd0) begin
                  expect_in   = 1'b1;
                  raw_left_in = 7'd0;
               end else begin
                  raw_left_in = raw_left_ff - 7'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff   <= 1'b1;
         is_run_ff   <= 1'b0;
         raw_left_ff <= 7'd0;
         pos_ff      <= 2'd0;
         gathered_ff <= 24'd0;
         done_ff     <= '0;
         run_len_ff  <= 8'd1;
      end else if (fire) begin
         expect_ff   <= expect_in;
         is_run_ff   <= is_run_in;
         raw_left_ff <= raw_left_in;
         pos_ff      <= pos_in;
         gathered_ff <= gathered_in;
         done_ff     <= done_in;
         run_len_ff  <= run_len_in;
      end
   end

   // two-entry result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop && push) begin
         main_valid_ff <= 1'b1;
      end else if (pop) begin
         main_valid_ff <= skid_valid_ff;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         if (main_valid_ff) skid_valid_ff <= 1'b1;
         else               main_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && push) begin
         main_ff <= result;
      end else if (pop) begin
         main_ff <= skid_ff;
      end else if (push) begin
         if (main_valid_ff) skid_ff <= result;
         else               main_ff <= result;
      end
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {main_ff.repeat_count, main_ff.alpha, main_ff.blue,
                        main_ff.green, main_ff.red};
   assign rsp_tlast  = main_ff.last_pixel;

`ifndef ASSERT_OFF
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without main entry");

   a_packet_no_result: assert property (@(posedge clock) disable iff (reset)
      (fire && packet_phase) |=> $stable(main_valid_ff) || $fell(main_valid_ff)
                                 || $past(pop))
      else $error("packet byte produced a result");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      push |-> (count != 8'd0))
      else $error("zero repeat count pushed");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (push && last) |=> (done_ff == '0) && (pos_ff == 2'd0) && expect_ff)
      else $error("stream state not cleared after last pixel");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && skid_valid_ff) |-> !req_tready)
      else $error("input taken while result buffer full");
`endif

endmodule
